@@ hw/rtl/bmr_pkg.sv @@
package bmr_pkg;

  localparam int LANES = 4;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef logic [15:0] bf16_t;
  typedef logic [31:0] fp32_t;

  // per-cell control for one clock
  typedef struct packed {
    logic load;    // capture a new product
    logic acc_en;  // fold the held product into the sum
    logic clr;     // start from +0.0 instead of the held sum
  } cell_ctl_t;

  function automatic logic [3:0] lzc16(input logic [15:0] v);
    logic [3:0] n;
    logic       found;
    n = 4'd0;
    found = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        n = 4'(15 - i);
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        n = 5'(26 - i);
      end
    end
    return n;
  endfunction

  // bf16 x bf16 rounded to fp32 (exact unless the result is subnormal or overflows)
  function automatic fp32_t bf16_mul(input bf16_t a, input bf16_t b);
    logic        sgn;
    logic [7:0]  ea, eb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0]  ma, mb;
    logic [15:0] p, nrm;
    logic [3:0]  lz;
    logic signed [10:0] e;
    logic [10:0] sh;
    logic [49:0] x;
    logic [23:0] keep;
    logic        g, st, inc;
    fp32_t       res;
    sgn = a[15] ^ b[15];
    ea = a[14:7];
    eb = b[14:7];
    a_nan = (ea == 8'hFF) && (a[6:0] != 7'd0);
    b_nan = (eb == 8'hFF) && (b[6:0] != 7'd0);
    a_inf = (ea == 8'hFF) && (a[6:0] == 7'd0);
    b_inf = (eb == 8'hFF) && (b[6:0] == 7'd0);
    a_zero = a[14:0] == 15'd0;
    b_zero = b[14:0] == 15'd0;
    ma = {ea != 8'd0, a[6:0]};
    mb = {eb != 8'd0, b[6:0]};
    p = ma * mb;
    lz = lzc16(p);
    nrm = p << lz;
    e = $signed({3'b0, (ea == 8'd0) ? 8'd1 : ea}) + $signed({3'b0, (eb == 8'd0) ? 8'd1 : eb})
        - 11'sd126 - $signed({7'b0, lz});
    sh = 11'(11'sd1 - e);
    if (sh > 11'd31) sh = 11'd31;
    x = {nrm, 34'b0} >> sh[4:0];
    keep = x[49:26];
    g = x[25];
    st = |x[24:0];
    inc = g & (st | keep[0]);
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      res = CANON_NAN;
    end else if (a_inf || b_inf) begin
      res = {sgn, 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      res = {sgn, 31'd0};
    end else if (e >= 11'sd255) begin
      res = {sgn, 8'hFF, 23'd0};
    end else if (e >= 11'sd1) begin
      res = {sgn, e[7:0], nrm[14:0], 8'd0};
    end else begin
      res = {sgn, 31'd0} + {8'd0, keep} + {31'd0, inc};
    end
    return res;
  endfunction

  // fp32 + fp32, round to nearest even
  function automatic fp32_t fp32_add(input fp32_t x, input fp32_t y);
    logic        x_nan, y_nan, x_inf, y_inf, sub;
    fp32_t       big, sml, res;
    logic [7:0]  be, se, d;
    logic [26:0] sw0, sw;
    logic        sticky;
    logic [27:0] bw, sum;
    logic [26:0] n;
    logic [4:0]  lz;
    logic [8:0]  e, lim, s;
    logic        inc;
    logic [7:0]  ef;
    x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    x_inf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    y_inf = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
    if (x[30:0] < y[30:0]) begin
      big = y;
      sml = x;
    end else begin
      big = x;
      sml = y;
    end
    be = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    se = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d = be - se;
    sw0 = {sml[30:23] != 8'd0, sml[22:0], 3'b0};
    if (d >= 8'd27) begin
      sw = 27'd0;
      sticky = |sw0;
    end else begin
      sw = sw0 >> d[4:0];
      sticky = |(sw0 & ((27'd1 << d[4:0]) - 27'd1));
    end
    sw[0] = sw[0] | sticky;
    bw = {1'b0, big[30:23] != 8'd0, big[22:0], 3'b0};
    sub = x[31] ^ y[31];
    sum = sub ? (bw - {1'b0, sw}) : (bw + {1'b0, sw});
    lz = lzc27(sum[26:0]);
    lim = {1'b0, be} - 9'd1;
    if (sum[27]) begin
      n = {sum[27:2], sum[1] | sum[0]};
      e = {1'b0, be} + 9'd1;
    end else begin
      s = ({4'd0, lz} < lim) ? {4'd0, lz} : lim;
      n = sum[26:0] << s;
      e = {1'b0, be} - s;
    end
    ef = n[26] ? e[7:0] : 8'd0;
    inc = n[2] & (n[1] | n[0] | n[3]);
    if (x_nan || y_nan || (x_inf && y_inf && sub)) begin
      res = CANON_NAN;
    end else if (x_inf || y_inf) begin
      res = big;
    end else if (sum == 28'd0) begin
      res = {sub ? 1'b0 : big[31], 31'd0};
    end else if (e >= 9'd255) begin
      res = {big[31], 8'hFF, 23'd0};
    end else begin
      res = {big[31], ef, n[25:3]} + {31'd0, inc};
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/bmr_if.sv @@
interface bmr_in_if;
  logic                valid;
  logic                ready;
  logic [15:0]         a_value;
  logic [15:0]         b_lane0;
  logic [15:0]         b_lane1;
  logic [15:0]         b_lane2;
  logic [15:0]         b_lane3;
  logic                start_row;
  logic                finish_row;
  modport source (output valid, a_value, b_lane0, b_lane1, b_lane2, b_lane3,
                  start_row, finish_row, input ready);
  modport sink (input valid, a_value, b_lane0, b_lane1, b_lane2, b_lane3,
                start_row, finish_row, output ready);
endinterface

interface bmr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] c_lane0;
  logic [31:0] c_lane1;
  logic [31:0] c_lane2;
  logic [31:0] c_lane3;
  modport source (output valid, c_lane0, c_lane1, c_lane2, c_lane3, input ready);
  modport sink (input valid, c_lane0, c_lane1, c_lane2, c_lane3, output ready);
endinterface

@@ hw/rtl/bf16_mac_row_fp32_accumulate.sv @@
// bf16 row multiply-accumulate into four fp32 lane sums.
// in_ch: one item per cycle while ready is high; each holds an A element,
//   four B elements and start_row / finish_row; accepted when valid and ready are high.
// out_ch: one item per finish_row, the four fp32 sums after that item's add.
// Each lane cell forms the product into its product register and then folds
// it into its accumulator; the accumulator add is the loop that sets the
// rate of one item per cycle while in_ch.ready is high.
// A finish_row item goes from the product register into the output register
// that drives out_ch once it can leave the product stage.
// Stall: the output register holds an unread result; items keep flowing in
// until a second finish_row item reaches the accumulate stage, where it
// waits and in_ch.ready drops until the result is taken.
// Reset (rst_n low, synchronous): accumulators go to +0.0, both channels
// empty.
module bf16_mac_row_fp32_accumulate (
  input  logic clk,
  input  logic rst_n,
  bmr_in_if.sink    in_ch,
  bmr_out_if.source out_ch
);

  localparam int L = bmr_pkg::LANES;

  logic                s1_valid_r, s1_start_r, s1_fin_r;
  logic                out_valid_r;
  logic                in_ready, in_fire, s1_move;
  bmr_pkg::fp32_t      c_r [L];
  bmr_pkg::fp32_t      sums [L];
  bmr_pkg::bf16_t      b_vec [L];
  bmr_pkg::bf16_t      a_chain [L+1];
  bmr_pkg::cell_ctl_t  ctl;

  assign b_vec[0] = in_ch.b_lane0;
  assign b_vec[1] = in_ch.b_lane1;
  assign b_vec[2] = in_ch.b_lane2;
  assign b_vec[3] = in_ch.b_lane3;
  assign a_chain[0] = in_ch.a_value;

  // hold the stage only if it would overwrite an unread result
  assign in_ready = !(s1_valid_r && s1_fin_r && out_valid_r && !out_ch.ready);
  assign in_fire  = in_ch.valid && in_ready;
  assign s1_move  = s1_valid_r && in_ready;

  assign ctl.load   = in_fire;
  assign ctl.acc_en = s1_move;
  assign ctl.clr    = s1_start_r;

  for (genvar i = 0; i < L; i++) begin : g_cell
    bmr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .a_in    (a_chain[i]),
      .b_in    (b_vec[i]),
      .a_out   (a_chain[i+1]),
      .sum_nxt (sums[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_start_r <= in_ch.start_row;
      s1_fin_r   <= in_ch.finish_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move && s1_fin_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_fin_r) begin
      c_r <= sums;
    end
  end

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.c_lane0 = c_r[0];
  assign out_ch.c_lane1 = c_r[1];
  assign out_ch.c_lane2 = c_r[2];
  assign out_ch.c_lane3 = c_r[3];

  a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && s1_fin_r |=> out_valid_r)
    else $error("finish item did not produce a result");

  a_nofin_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && !s1_fin_r |=> out_valid_r == $past(out_valid_r && !out_ch.ready))
    else $error("result valid changed without a finish item");

  a_accept_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted item missing from product stage");

endmodule

@@ hw/rtl/bmr_cell.sv @@
module bmr_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  bmr_pkg::cell_ctl_t ctl,
  input  bmr_pkg::bf16_t     a_in,
  input  bmr_pkg::bf16_t     b_in,
  output bmr_pkg::bf16_t     a_out,
  output bmr_pkg::fp32_t     sum_nxt
);

  bmr_pkg::fp32_t prod_r;
  bmr_pkg::fp32_t acc_r;

  // hand the A operand on to the next cell
  assign a_out = a_in;

  always_comb begin
    sum_nxt = bmr_pkg::fp32_add(ctl.clr ? 32'd0 : acc_r, prod_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r <= bmr_pkg::bf16_mul(a_in, b_in);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 32'd0;
    end else if (ctl.acc_en) begin
      acc_r <= sum_nxt;
    end
  end

endmodule
